### rtl/rgbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared types and constants of the RGB response frame classifier.
// ----------------------------------------------------------------------------
package rgbc_pkg;

  localparam int FRAME_MAX_DEF = 40;

  localparam int BYTE_W  = 8;
  localparam int VAL_W   = 10;
  localparam int CLS_W   = 3;
  localparam int FL_W    = 6;
  localparam int DC_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [VAL_W-1:0] DARK_LIMIT_RST   = 10'd45;
  localparam logic [VAL_W-1:0] BRIGHT_LIMIT_RST = 10'd200;

  localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LIMIT = 2'd1;

  localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_O    = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_K    = 8'h4B;
  localparam logic [BYTE_W-1:0] CH_R    = 8'h52;
  localparam logic [BYTE_W-1:0] CH_G    = 8'h47;
  localparam logic [BYTE_W-1:0] CH_B    = 8'h42;
  localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9    = 8'h39;

  localparam logic [CLS_W-1:0] CLS_GREEN = 3'd0;
  localparam logic [CLS_W-1:0] CLS_WHITE = 3'd1;
  localparam logic [CLS_W-1:0] CLS_RED   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_BLACK = 3'd3;
  localparam logic [CLS_W-1:0] CLS_BLUE  = 3'd4;
  localparam logic [CLS_W-1:0] CLS_NONE  = 3'd5;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_FR1  = 4'd1,
    PH_SK1  = 4'd2,
    PH_FR2  = 4'd3,
    PH_SK2  = 4'd4,
    PH_DR   = 4'd5,
    PH_FG   = 4'd6,
    PH_SKG  = 4'd7,
    PH_DG   = 4'd8,
    PH_FB   = 4'd9,
    PH_SKB  = 4'd10,
    PH_DB   = 4'd11,
    PH_DONE = 4'd12
  } phase_t;

  typedef struct packed {
    logic [VAL_W-1:0] dark_limit;
    logic [VAL_W-1:0] bright_limit;
  } limits_t;

  typedef struct packed {
    logic [CLS_W-1:0] color_class;
    logic [VAL_W-1:0] red_value;
    logic [VAL_W-1:0] green_value;
    logic [VAL_W-1:0] blue_value;
    logic             parse_ok;
  } result_t;

endpackage

`default_nettype wire

### rtl/rgbc_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_parser
// Per-byte frame tracker and field parser; forms the result at frame end.
// ----------------------------------------------------------------------------
module rgbc_parser
  import rgbc_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_en,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire limits_t           limits,
  output logic                   res_valid,
  output result_t                res
);

  phase_t            phase_r, phase_nxt;
  logic [FL_W-1:0]   frame_len_r, frame_len_nxt;
  logic [BYTE_W-1:0] prev_byte_r;
  logic [DC_W-1:0]   digit_cnt_r, digit_cnt_nxt;
  logic [VAL_W-1:0]  red_acc_r, red_acc_nxt;
  logic [VAL_W-1:0]  green_acc_r, green_acc_nxt;
  logic [VAL_W-1:0]  blue_acc_r, blue_acc_nxt;
  logic              error_r, error_nxt;

  phase_t            ph_parsed;
  logic [DC_W-1:0]   dc_parsed;
  logic [VAL_W-1:0]  r_parsed, g_parsed, b_parsed;
  logic              err_parsed;
  logic              is_digit;
  logic [VAL_W-1:0]  acc_sel, acc_upd;
  logic [FL_W-1:0]   len_inc;
  logic              frame_end;
  logic [VAL_W-1:0]  r_out, g_out, b_out;
  logic              ok;

  assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
  assign len_inc  = frame_len_r + FL_W'(1);

  always_comb begin
    case (phase_r)
      PH_DR:   acc_sel = red_acc_r;
      PH_DG:   acc_sel = green_acc_r;
      default: acc_sel = blue_acc_r;
    endcase
    acc_upd = (acc_sel << 3) + (acc_sel << 1) + VAL_W'(rx_byte - CH_0);
  end

  always_comb begin
    ph_parsed  = phase_r;
    dc_parsed  = digit_cnt_r;
    r_parsed   = red_acc_r;
    g_parsed   = green_acc_r;
    b_parsed   = blue_acc_r;
    err_parsed = error_r;
    case (phase_r)
      PH_FR1: begin
        if (rx_byte == CH_R) ph_parsed = PH_SK1;
      end
      PH_SK1: ph_parsed = PH_FR2;
      PH_FR2: begin
        if (rx_byte == CH_R) ph_parsed = PH_SK2;
      end
      PH_SK2: begin
        ph_parsed = PH_DR;
        dc_parsed = '0;
      end
      PH_SKG: begin
        ph_parsed = PH_DG;
        dc_parsed = '0;
      end
      PH_SKB: begin
        ph_parsed = PH_DB;
        dc_parsed = '0;
      end
      PH_FG: begin
        if (rx_byte == CH_G) ph_parsed = PH_SKG;
      end
      PH_FB: begin
        if (rx_byte == CH_B) ph_parsed = PH_SKB;
      end
      PH_DR, PH_DG, PH_DB: begin
        if (is_digit) begin
          if (digit_cnt_r < DC_W'(3)) begin
            if (phase_r == PH_DR) r_parsed = acc_upd;
            else if (phase_r == PH_DG) g_parsed = acc_upd;
            else b_parsed = acc_upd;
          end
          if (digit_cnt_r < DC_W'(4)) dc_parsed = digit_cnt_r + DC_W'(1);
        end else if ((digit_cnt_r == '0) || (digit_cnt_r > DC_W'(3))) begin
          if (phase_r == PH_DR) r_parsed = '0;
          else if (phase_r == PH_DG) g_parsed = '0;
          else b_parsed = '0;
          err_parsed = 1'b1;
          ph_parsed  = PH_DONE;
        end else if (phase_r == PH_DR) begin
          ph_parsed = (rx_byte == CH_G) ? PH_SKG : PH_FG;
        end else if (phase_r == PH_DG) begin
          ph_parsed = (rx_byte == CH_B) ? PH_SKB : PH_FB;
        end else begin
          ph_parsed = PH_DONE;
        end
      end
      default: ph_parsed = phase_r;
    endcase
  end

  assign frame_end = (phase_r != PH_IDLE) &&
                     (((prev_byte_r == CH_O) && (rx_byte == CH_K) &&
                       (len_inc >= FL_W'(2))) ||
                      (len_inc >= FL_W'(FRAME_MAX)));

  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    digit_cnt_nxt = digit_cnt_r;
    red_acc_nxt   = red_acc_r;
    green_acc_nxt = green_acc_r;
    blue_acc_nxt  = blue_acc_r;
    error_nxt     = error_r;
    if (phase_r == PH_IDLE) begin
      if (rx_byte == CH_PLUS) begin
        phase_nxt     = PH_FR1;
        frame_len_nxt = FL_W'(1);
        digit_cnt_nxt = '0;
        red_acc_nxt   = '0;
        green_acc_nxt = '0;
        blue_acc_nxt  = '0;
        error_nxt     = 1'b0;
      end
    end else begin
      digit_cnt_nxt = dc_parsed;
      red_acc_nxt   = r_parsed;
      green_acc_nxt = g_parsed;
      blue_acc_nxt  = b_parsed;
      error_nxt     = err_parsed;
      if (frame_end) begin
        phase_nxt     = PH_IDLE;
        frame_len_nxt = '0;
      end else begin
        phase_nxt     = ph_parsed;
        frame_len_nxt = len_inc;
      end
    end
  end

  always_comb begin
    r_out = (ph_parsed == PH_DR) ? '0 : r_parsed;
    g_out = (ph_parsed == PH_DG) ? '0 : g_parsed;
    b_out = (ph_parsed == PH_DB) ? '0 : b_parsed;
    ok    = (ph_parsed == PH_DONE) && !err_parsed;
    res.color_class = CLS_NONE;
    if (ok) begin
      if ((r_out < limits.dark_limit) && (g_out < limits.dark_limit) &&
          (b_out < limits.dark_limit)) begin
        res.color_class = CLS_BLACK;
      end else if ((r_out > limits.bright_limit) && (g_out > limits.bright_limit) &&
                   (b_out > limits.bright_limit)) begin
        res.color_class = CLS_WHITE;
      end else if ((r_out > g_out) && (r_out > b_out)) begin
        res.color_class = CLS_RED;
      end else if ((g_out > r_out) && (g_out > b_out)) begin
        res.color_class = CLS_GREEN;
      end else if ((b_out > r_out) && (b_out > g_out)) begin
        res.color_class = CLS_BLUE;
      end
    end
    res.red_value   = r_out;
    res.green_value = g_out;
    res.blue_value  = b_out;
    res.parse_ok    = ok;
  end

  assign res_valid = byte_en && frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      frame_len_r <= '0;
      prev_byte_r <= '0;
      digit_cnt_r <= '0;
      red_acc_r   <= '0;
      green_acc_r <= '0;
      blue_acc_r  <= '0;
      error_r     <= 1'b0;
    end else if (byte_en) begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      prev_byte_r <= rx_byte;
      digit_cnt_r <= digit_cnt_nxt;
      red_acc_r   <= red_acc_nxt;
      green_acc_r <= green_acc_nxt;
      blue_acc_r  <= blue_acc_nxt;
      error_r     <= error_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/rgb_response_frame_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_response_frame_classifier
// Parses framed RGB sensor replies byte by byte and classifies the color.
// The result of a frame-ending byte is registered in the output or skid entry.
// Throughput: one byte per cycle; a two-entry output buffer absorbs stalls.
// Input stalls only while both output entries hold untaken results.
// Reset: synchronous, active low; parser idle, limits back to 45 and 200.
// ----------------------------------------------------------------------------
module rgb_response_frame_classifier
  import rgbc_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CLS_W-1:0]          out_color_class,
  output logic [VAL_W-1:0]          out_red_value,
  output logic [VAL_W-1:0]          out_green_value,
  output logic [VAL_W-1:0]          out_blue_value,
  output logic                      out_parse_ok,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VAL_W-1:0]     cfg_data
);

  limits_t limits_r;
  logic    in_xfer;
  logic    res_valid;
  result_t res;
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;
  logic    out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.dark_limit   <= DARK_LIMIT_RST;
      limits_r.bright_limit <= BRIGHT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DARK_LIMIT:   limits_r.dark_limit   <= cfg_data;
        CFG_BRIGHT_LIMIT: limits_r.bright_limit <= cfg_data;
        default:          limits_r              <= limits_r;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !in_stall;

  rgbc_parser #(
    .FRAME_MAX (FRAME_MAX)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_xfer),
    .rx_byte   (in_rx_byte),
    .limits    (limits_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= res_valid;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else begin
        out_r  <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_class = out_r.color_class;
  assign out_red_value   = out_r.red_value;
  assign out_green_value = out_r.green_value;
  assign out_blue_value  = out_r.blue_value;
  assign out_parse_ok    = out_r.parse_ok;

endmodule

`default_nettype wire

### dv/rgbc_reading_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgbc_reading_checker
// Watches the byte, result and register channels of the RGB frame classifier.
// Tracks the frame parser and the two limits on every transfer, queues the
// reading that each frame end should produce and compares every result
// transfer field by field against the oldest queued reading.
// ----------------------------------------------------------------------------
module rgbc_reading_checker
  import rgbc_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CLS_W-1:0]     out_color_class,
  input  logic [VAL_W-1:0]     out_red_value,
  input  logic [VAL_W-1:0]     out_green_value,
  input  logic [VAL_W-1:0]     out_blue_value,
  input  logic                 out_parse_ok,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   readings_due
);

  phase_t            phase;
  logic [FL_W-1:0]   frame_len;
  logic [BYTE_W-1:0] last_byte;
  logic [DC_W-1:0]   digits;
  logic [VAL_W-1:0]  chan_acc [3];
  logic              err_seen;
  limits_t           limits;
  result_t           readings [$];
  int                errors = 0;

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  task automatic parse_sensor_byte(input logic [BYTE_W-1:0] rx);
    logic [BYTE_W-1:0] last;
    int                ch;
    logic              ok;
    result_t           rd;
    last = last_byte;
    last_byte = rx;
    if (phase == PH_IDLE) begin
      if (rx == CH_PLUS) begin
        phase     = PH_FR1;
        frame_len = FL_W'(1);
        digits    = '0;
        chan_acc  = '{default: '0};
        err_seen  = 1'b0;
      end
      return;
    end
    frame_len = frame_len + 1'b1;
    ch = (phase == PH_DR) ? 0 : (phase == PH_DG) ? 1 : 2;
    case (phase)
      PH_FR1: if (rx == CH_R) phase = PH_SK1;
      PH_SK1: phase = PH_FR2;
      PH_FR2: if (rx == CH_R) phase = PH_SK2;
      PH_SK2, PH_SKG, PH_SKB: begin
        phase  = phase_t'(phase + 1'b1);
        digits = '0;
      end
      PH_FG: if (rx == CH_G) phase = PH_SKG;
      PH_FB: if (rx == CH_B) phase = PH_SKB;
      PH_DR, PH_DG, PH_DB: begin
        if (rx >= CH_0 && rx <= CH_9) begin
          if (digits < 3) chan_acc[ch] = VAL_W'(chan_acc[ch] * 10 + (rx - CH_0));
          if (digits < 4) digits = digits + 1'b1;
        end else if (digits == 0 || digits > 3) begin
          chan_acc[ch] = '0;
          err_seen     = 1'b1;
          phase        = PH_DONE;
        end else if (phase == PH_DR) begin
          phase = (rx == CH_G) ? PH_SKG : PH_FG;
        end else if (phase == PH_DG) begin
          phase = (rx == CH_B) ? PH_SKB : PH_FB;
        end else begin
          phase = PH_DONE;
        end
      end
      default: ;
    endcase

    if ((last == CH_O && rx == CH_K && frame_len >= 2) || frame_len >= FRAME_MAX) begin
      ok             = (phase == PH_DONE) && !err_seen;
      rd.red_value   = (phase == PH_DR) ? '0 : chan_acc[0];
      rd.green_value = (phase == PH_DG) ? '0 : chan_acc[1];
      rd.blue_value  = (phase == PH_DB) ? '0 : chan_acc[2];
      rd.parse_ok    = ok;
      rd.color_class = CLS_NONE;
      if (ok) begin
        if (rd.red_value < limits.dark_limit && rd.green_value < limits.dark_limit &&
            rd.blue_value < limits.dark_limit) begin
          rd.color_class = CLS_BLACK;
        end else if (rd.red_value > limits.bright_limit &&
                     rd.green_value > limits.bright_limit &&
                     rd.blue_value > limits.bright_limit) begin
          rd.color_class = CLS_WHITE;
        end else if (rd.red_value > rd.green_value && rd.red_value > rd.blue_value) begin
          rd.color_class = CLS_RED;
        end else if (rd.green_value > rd.red_value && rd.green_value > rd.blue_value) begin
          rd.color_class = CLS_GREEN;
        end else if (rd.blue_value > rd.red_value && rd.blue_value > rd.green_value) begin
          rd.color_class = CLS_BLUE;
        end
      end
      readings.push_back(rd);
      phase     = PH_IDLE;
      frame_len = '0;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      phase     = PH_IDLE;
      frame_len = '0;
      last_byte = '0;
      digits    = '0;
      chan_acc  = '{default: '0};
      err_seen  = 1'b0;
      limits.dark_limit   = DARK_LIMIT_RST;
      limits.bright_limit = BRIGHT_LIMIT_RST;
      readings.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (readings.size() == 0) begin
          errors++;
          $display({"%0t: unexpected result, expected none, ",
                    "actual class %0d r %0d g %0d b %0d ok %0d"},
                   $time, out_color_class, out_red_value, out_green_value, out_blue_value,
                   out_parse_ok);
        end else begin
          want = readings.pop_front();
          check_field("color_class", want.color_class, out_color_class);
          check_field("red_value", want.red_value, out_red_value);
          check_field("green_value", want.green_value, out_green_value);
          check_field("blue_value", want.blue_value, out_blue_value);
          check_field("parse_ok", want.parse_ok, out_parse_ok);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DARK_LIMIT:   limits.dark_limit = cfg_data;
          CFG_BRIGHT_LIMIT: limits.bright_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_sensor_byte(in_rx_byte);
    end
    fail_count   <= errors;
    readings_due <= readings.size();
  end

endmodule

### dv/rgb_response_frame_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_response_frame_classifier_tb
// Feeds sensor reply frames into the classifier: a few hand-built frames,
// then mostly well-formed frames with random values and some broken ones
// (empty or long digit runs, cut frames, overlong frames, pure noise).
// Limits are rewritten between phases, sender gaps and result stalls vary
// by phase, and one long result hold-off fills the output buffer.
// ----------------------------------------------------------------------------
module rgb_response_frame_classifier_tb;
  import rgbc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 4;
  localparam int PHASE_ITEMS = 182;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum {
    FR_CLEAN,
    FR_NO_DIGITS,
    FR_LONG_RUN,
    FR_TRUNCATED,
    FR_OVERLONG,
    FR_NOISE
  } frame_kind_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CLS_W-1:0]     out_color_class;
  logic [VAL_W-1:0]     out_red_value;
  logic [VAL_W-1:0]     out_green_value;
  logic [VAL_W-1:0]     out_blue_value;
  logic                 out_parse_ok;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  int                   fail_count;
  int                   readings_due;
  int                   cycle_count = 0;
  int                   items_sent = 0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  logic                 holding = 1'b0;
  event                 hold_outputs;
  logic [BYTE_W-1:0]    frame_bytes [$];

  int dark_plan   [8] = '{45, 0, 1023, -1, 60, 0, 1023, -1};
  int bright_plan [8] = '{200, 1023, 0, -1, 150, 0, 1023, -1};

  rgb_response_frame_classifier DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_color_class (out_color_class),
    .out_red_value   (out_red_value),
    .out_green_value (out_green_value),
    .out_blue_value  (out_blue_value),
    .out_parse_ok    (out_parse_ok),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  rgbc_reading_checker u_reading_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_color_class (out_color_class),
    .out_red_value   (out_red_value),
    .out_green_value (out_green_value),
    .out_blue_value  (out_blue_value),
    .out_parse_ok    (out_parse_ok),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .readings_due    (readings_due)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= holding || ($urandom_range(99) < recv_stall_pct);
  end

  always begin
    @(hold_outputs);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  function automatic int pick_level(input int tone);
    case (tone)
      0:       return $urandom_range(60);
      1:       return $urandom_range(999, 150);
      default: return $urandom_range(999);
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] filler();
    return BYTE_W'($urandom_range(8'h7A, 8'h61));
  endfunction

  task automatic push_digits(input int v, input int n);
    int div;
    div = 1;
    repeat (n - 1) div *= 10;
    repeat (n) begin
      frame_bytes.push_back(BYTE_W'(CH_0 + (v / div) % 10));
      div /= 10;
    end
  endtask

  task automatic build_reading_frame(input frame_kind_t kind);
    int level [3];
    int ndig  [3];
    int tone;
    int bad_ch;
    int tie;
    int cut;
    frame_bytes = {};
    frame_bytes.push_back(CH_PLUS);
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(45, 5)) frame_bytes.push_back(BYTE_W'($urandom_range(255)));
      frame_bytes.push_back(CH_O);
      frame_bytes.push_back(CH_K);
      return;
    end
    tone = $urandom_range(2);
    foreach (level[ch]) level[ch] = pick_level(tone);
    if ($urandom_range(4) == 0) begin
      tie = $urandom_range(2);
      level[(tie + 1) % 3] = level[tie];
    end
    foreach (ndig[ch]) begin
      ndig[ch] = (level[ch] >= 100) ? 3 : (level[ch] >= 10) ? 2 : 1;
      ndig[ch] = $urandom_range(3, ndig[ch]);
    end
    bad_ch = $urandom_range(2);
    if (kind == FR_NO_DIGITS) ndig[bad_ch] = 0;
    if (kind == FR_LONG_RUN) begin
      ndig[bad_ch]  = $urandom_range(6, 4);
      level[bad_ch] = $urandom_range(999999);
    end

    repeat ($urandom_range(2)) frame_bytes.push_back(filler());
    frame_bytes.push_back(CH_R);
    frame_bytes.push_back(BYTE_W'($urandom_range(255)));
    frame_bytes.push_back(CH_R);
    frame_bytes.push_back(BYTE_W'($urandom_range(255)));
    push_digits(level[0], ndig[0]);
    repeat ($urandom_range(2)) frame_bytes.push_back(filler());
    frame_bytes.push_back(CH_G);
    frame_bytes.push_back(BYTE_W'($urandom_range(255)));
    push_digits(level[1], ndig[1]);
    repeat ($urandom_range(2)) frame_bytes.push_back(filler());
    frame_bytes.push_back(CH_B);
    frame_bytes.push_back(BYTE_W'($urandom_range(255)));
    push_digits(level[2], ndig[2]);
    repeat ($urandom_range(2)) frame_bytes.push_back(filler());

    if (kind == FR_OVERLONG) begin
      while (frame_bytes.size() < 44) frame_bytes.push_back(filler());
      return;
    end
    if (kind == FR_TRUNCATED) begin
      cut = $urandom_range(frame_bytes.size() - 1, 2);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    frame_bytes.push_back(CH_O);
    frame_bytes.push_back(CH_K);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame();
    logic [BYTE_W-1:0] noise;
    repeat ($urandom_range(2)) begin
      noise = BYTE_W'($urandom_range(255));
      if (noise == CH_PLUS) noise = CH_O;
      send_byte(noise);
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    items_sent += frame_bytes.size();
  endtask

  task automatic wait_readings_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= VAL_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  initial begin
    int          pick;
    int          dark;
    int          bright;
    frame_kind_t kind;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 'O' just before the start byte, 'K' as the first frame byte, extreme skip
    // bytes, a full-scale red and an over-long green run
    frame_bytes = {CH_O, CH_PLUS, CH_K, CH_R, 8'hFF, CH_R, 8'h00, CH_9, CH_9, CH_9,
                   CH_G, 8'h3A, CH_9, CH_9, CH_9, CH_9, CH_O, CH_K};
    send_frame();
    // plus inside the frame, equal channels with no strict maximum
    frame_bytes = {CH_PLUS, CH_R, CH_PLUS, CH_R, 8'h3A, 8'h31, CH_0, CH_0,
                   CH_G, 8'h3A, 8'h31, CH_0, CH_0, CH_B, 8'h3A, 8'h31, CH_0, CH_0,
                   CH_O, CH_K};
    send_frame();
    wait_readings_done();

    // hold results off long enough for the output buffer to fill
    -> hold_outputs;
    repeat (12) begin
      build_reading_frame(FR_CLEAN);
      send_frame();
    end
    wait_readings_done();

    for (int s = 0; s < 8; s++) begin
      wait_readings_done();
      dark   = (dark_plan[s] < 0) ? $urandom_range(1023) : dark_plan[s];
      bright = (bright_plan[s] < 0) ? $urandom_range(1023) : bright_plan[s];
      write_limit(CFG_DARK_LIMIT, dark);
      write_limit(CFG_BRIGHT_LIMIT, bright);
      if (s == 3) begin
        write_limit(CFG_SPARE_A, $urandom_range(1023));
        write_limit(CFG_SPARE_B, $urandom_range(1023));
      end
      cfg_valid <= 1'b0;
      case (s % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 48;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 48;
        end
        default: begin
          send_idle_pct = 27;
          recv_stall_pct <= 27;
        end
      endcase
      while (items_sent < (s + 1) * PHASE_ITEMS) begin
        pick = $urandom_range(99);
        kind = (pick < 70) ? FR_CLEAN :
               (pick < 76) ? FR_NO_DIGITS :
               (pick < 82) ? FR_LONG_RUN :
               (pick < 88) ? FR_TRUNCATED :
               (pick < 94) ? FR_OVERLONG : FR_NOISE;
        build_reading_frame(kind);
        send_frame();
      end
    end

    wait_readings_done();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### rgb_response_frame_classifier.f
rtl/rgbc_pkg.sv
rtl/rgbc_parser.sv
rtl/rgb_response_frame_classifier.sv
dv/rgbc_reading_checker.sv
dv/rgb_response_frame_classifier_tb.sv
